// ===== rtl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by the tracker, the emitter and the top level.
`timescale 1ns / 1ps

package u8d_pkg;

   localparam int CODE_W  = 21;
   localparam int COUNT_W = 3;
   localparam int HELD_W  = 2;

   localparam logic [CODE_W-1:0] REPLACEMENT_RESET = 21'h00FFFD;

   localparam logic [COUNT_W-1:0] LEN_NONE = 3'd0;
   localparam logic [COUNT_W-1:0] LEN_ONE  = 3'd1;
   localparam logic [COUNT_W-1:0] LEN_TWO  = 3'd2;
   localparam logic [COUNT_W-1:0] LEN_THREE = 3'd3;
   localparam logic [COUNT_W-1:0] LEN_FOUR = 3'd4;

   // Results caused by one input byte: a run of replacements, then an
   // optional final result.
   typedef struct packed {
      logic [HELD_W-1:0]  rep_count;
      logic               tail_valid;
      logic [CODE_W-1:0]  tail_code;
      logic [COUNT_W-1:0] tail_count;
      logic               tail_bad;
      logic               text_last;
   } job_type;

endpackage

// ===== rtl/u8d_tracker.sv =====
// Sequence tracker: holds the pending multi-byte sequence and turns each
// accepted byte into a job for the emitter. Depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_tracker import u8d_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        text_byte,
   input  logic              text_last,
   input  logic [CODE_W-1:0] replacement_code,
   output job_type           job
);

   logic [COUNT_W-1:0] expected_ff, expected_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [CODE_W-1:0]  partial_ff, partial_in;

   logic               f_tail_valid;
   logic [CODE_W-1:0]  f_code;
   logic [COUNT_W-1:0] f_count;
   logic               f_bad;
   logic               f_start;
   logic [COUNT_W-1:0] f_len;
   logic [2:0]         f_bits_lo;
   logic [4:0]         f_bits;
   logic               is_cont;
   logic [COUNT_W-1:0] held_sum;
   logic [CODE_W-1:0]  gathered;

   assign is_cont  = (text_byte[7:6] == 2'b10);
   assign held_sum = {1'b0, held_ff} + LEN_ONE;
   assign gathered = {partial_ff[CODE_W-7:0], text_byte[5:0]};
   assign f_bits_lo = text_byte[2:0];

   // Decode of a byte with no sequence pending.
   always_comb begin
      f_tail_valid = 1'b1;
      f_code       = replacement_code;
      f_count      = LEN_ONE;
      f_bad        = 1'b1;
      f_start      = 1'b0;
      f_len        = LEN_NONE;
      f_bits       = '0;
      priority if (!text_byte[7]) begin
         f_code = {13'd0, text_byte};
         f_bad  = 1'b0;
      end else if (text_byte[7:5] == 3'b110) begin
         f_len  = LEN_TWO;
         f_bits = text_byte[4:0];
      end else if (text_byte[7:4] == 4'b1110) begin
         f_len  = LEN_THREE;
         f_bits = {1'b0, text_byte[3:0]};
      end else if (text_byte[7:3] == 5'b11110) begin
         f_len  = LEN_FOUR;
         f_bits = {2'b00, f_bits_lo};
      end else begin
         f_len  = LEN_NONE;
      end
      if (f_len != LEN_NONE && !text_last) begin
         f_tail_valid = 1'b0;
         f_start      = 1'b1;
      end
   end

   always_comb begin
      job         = '0;
      job.text_last = text_last;
      expected_in = expected_ff;
      held_in     = held_ff;
      partial_in  = partial_ff;
      if (expected_ff != LEN_NONE && is_cont) begin
         if (held_sum >= expected_ff) begin
            job.tail_valid = 1'b1;
            job.tail_code  = gathered;
            job.tail_count = expected_ff;
            expected_in    = LEN_NONE;
            held_in        = '0;
            partial_in     = '0;
         end else if (text_last) begin
            job.rep_count = held_sum[HELD_W-1:0];
         end else begin
            held_in    = held_sum[HELD_W-1:0];
            partial_in = gathered;
         end
      end else begin
         if (expected_ff != LEN_NONE) begin
            job.rep_count = held_ff;
         end
         job.tail_valid = f_tail_valid;
         job.tail_code  = f_code;
         job.tail_count = f_count;
         job.tail_bad   = f_bad;
         expected_in    = f_len;
         held_in        = f_start ? 2'd1 : 2'd0;
         partial_in     = {16'd0, f_bits};
         if (!f_start) begin
            expected_in = LEN_NONE;
            partial_in  = '0;
         end
      end
      if (text_last) begin
         expected_in = LEN_NONE;
         held_in     = '0;
         partial_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= LEN_NONE;
         held_ff     <= '0;
         partial_ff  <= '0;
      end else if (accept) begin
         expected_ff <= expected_in;
         held_ff     <= held_in;
         partial_ff  <= partial_in;
      end
   end

endmodule

// ===== rtl/u8d_emitter.sv =====
// Result register: holds the job of the last accepted byte and hands out
// its results one transaction at a time. Depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_emitter import u8d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  job_type            job_in,
   input  logic [CODE_W-1:0]  replacement_code,
   output logic               take_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CODE_W-1:0]  rsp_code_point,
   output logic [COUNT_W-1:0] rsp_byte_count,
   output logic               rsp_malformed,
   output logic               rsp_run_last,
   output logic               rsp_text_end
);

   job_type job_ff;
   logic    busy;
   logic    final_result;
   logic    reps_left;

   assign reps_left    = (job_ff.rep_count != '0);
   assign busy         = reps_left || job_ff.tail_valid;
   assign final_result = busy && (!reps_left ||
                         (job_ff.rep_count == 2'd1 && !job_ff.tail_valid));
   assign take_ready   = !busy || (rsp_ready && final_result);

   assign rsp_valid      = busy;
   assign rsp_code_point = reps_left ? replacement_code : job_ff.tail_code;
   assign rsp_byte_count = reps_left ? LEN_ONE : job_ff.tail_count;
   assign rsp_malformed  = reps_left ? 1'b1 : job_ff.tail_bad;
   assign rsp_run_last   = final_result;
   assign rsp_text_end   = final_result && job_ff.text_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.rep_count  <= '0;
         job_ff.tail_valid <= 1'b0;
      end else if (load) begin
         job_ff <= job_in;
      end else if (rsp_valid && rsp_ready) begin
         if (reps_left) begin
            job_ff.rep_count <= job_ff.rep_count - 2'd1;
         end else begin
            job_ff.tail_valid <= 1'b0;
         end
      end
   end

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_end |-> rsp_run_last)
      else $error("text end flagged on a result that does not close its run");

   a_malformed_one_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_malformed |-> rsp_byte_count == LEN_ONE)
      else $error("replacement result stands for more than one byte");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count != LEN_NONE && rsp_byte_count <= LEN_FOUR))
      else $error("byte count out of range");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_run_last && !load |=> !rsp_valid)
      else $error("results remain after the final result of a run");

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: configuration register, sequence
// tracker and result register. Depends on u8d_pkg, u8d_tracker, u8d_emitter.
`timescale 1ns / 1ps

// Usage:
// The req_ channel carries one byte of UTF-8 text per transaction, with
// req_text_last set on the final byte of the text. The rsp_ channel carries
// decoded code points; rsp_run_last marks the final result caused by one
// byte and rsp_text_end the final result of the whole text. A byte may cause
// no result (a lead byte or an unfinished continuation) or up to four
// results (replacements for held bytes, then the breaking byte itself).
// The csr_ channel writes the replacement code; it is always ready and is
// meant to be written while the decoder is idle.
// Latency: a result appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while each byte causes at most one result;
// a byte that causes several results holds the result register until all are
// taken, and the next byte is taken in the cycle its final result is taken.
// A stalled receiver holds the result register, and new bytes wait for as
// long as it holds results. Synchronous reset clears the pending sequence
// and the result register and sets the replacement code to U+FFFD.

module utf8_stream_decoder import u8d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_text_byte,
   input  logic               req_text_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CODE_W-1:0]  rsp_code_point,
   output logic [COUNT_W-1:0] rsp_byte_count,
   output logic               rsp_malformed,
   output logic               rsp_run_last,
   output logic               rsp_text_end,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CODE_W-1:0]  csr_replacement_code
);

   logic [CODE_W-1:0] replacement_ff;
   logic              accept;
   job_type           job;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         replacement_ff <= REPLACEMENT_RESET;
      end else if (csr_valid && csr_ready) begin
         replacement_ff <= csr_replacement_code;
      end
   end

   u8d_tracker tracker (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .text_byte        (req_text_byte),
      .text_last        (req_text_last),
      .replacement_code (replacement_ff),
      .job              (job)
   );

   u8d_emitter emitter (
      .clock            (clock),
      .reset            (reset),
      .load             (accept),
      .job_in           (job),
      .replacement_code (replacement_ff),
      .take_ready       (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_malformed    (rsp_malformed),
      .rsp_run_last     (rsp_run_last),
      .rsp_text_end     (rsp_text_end)
   );

endmodule

// ===== tb/sv/tb_utf8_stream_decoder.sv =====
// Self-checking testbench for utf8_stream_decoder: directed and random UTF-8 text with
// random idling on both channels, checked against a cycle-free decoder model.
// Depends on u8d_pkg and the utf8_stream_decoder RTL.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
   import u8d_pkg::*;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [COUNT_W-1:0] count;
      logic               bad;
      logic               run_last;
      logic               text_end;
   } point_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_text_byte;
   logic               req_text_last;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [CODE_W-1:0]  rsp_code_point;
   logic [COUNT_W-1:0] rsp_byte_count;
   logic               rsp_malformed;
   logic               rsp_run_last;
   logic               rsp_text_end;
   logic               csr_valid;
   logic               csr_ready;
   logic [CODE_W-1:0]  csr_replacement_code;

   point_type          expected_points[$];
   point_type          step_points[$];
   logic [CODE_W-1:0]  replacement_now;
   logic [COUNT_W-1:0] seq_len;
   logic [HELD_W-1:0]  seq_held;
   logic [CODE_W-1:0]  seq_bits;
   int                 error_count = 0;
   int                 stall_left = 0;
   logic               steady = 1'b0;

   utf8_stream_decoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_text_byte(req_text_byte),
      .req_text_last(req_text_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_code_point(rsp_code_point),
      .rsp_byte_count(rsp_byte_count),
      .rsp_malformed(rsp_malformed),
      .rsp_run_last(rsp_run_last),
      .rsp_text_end(rsp_text_end),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_replacement_code(csr_replacement_code)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   task automatic flag_error(input string what, input logic [31:0] got,
                             input logic [31:0] want);
      error_count++;
      if (error_count <= 100) begin
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      end
   endtask

   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 50);
   endfunction

   function automatic void clear_sequence();
      seq_len = LEN_NONE;
      seq_held = '0;
      seq_bits = '0;
   endfunction

   function automatic void add_point(input logic [CODE_W-1:0] code,
                                     input logic [COUNT_W-1:0] count, input logic bad);
      point_type p;
      p.code = code;
      p.count = count;
      p.bad = bad;
      p.run_last = 1'b0;
      p.text_end = 1'b0;
      step_points.push_back(p);
   endfunction

   function automatic void take_lead(input logic [7:0] b, input logic l);
      logic [COUNT_W-1:0] len;
      logic [CODE_W-1:0]  bits;
      len = LEN_NONE;
      bits = '0;
      if (!b[7]) begin
         add_point({13'd0, b}, LEN_ONE, 1'b0);
      end else begin
         if (b[7:5] == 3'b110) begin
            len = LEN_TWO;
            bits = {16'd0, b[4:0]};
         end else if (b[7:4] == 4'b1110) begin
            len = LEN_THREE;
            bits = {17'd0, b[3:0]};
         end else if (b[7:3] == 5'b11110) begin
            len = LEN_FOUR;
            bits = {18'd0, b[2:0]};
         end
         if (len == LEN_NONE || l) begin
            add_point(replacement_now, LEN_ONE, 1'b1);
         end else begin
            seq_len = len;
            seq_held = 2'd1;
            seq_bits = bits;
         end
      end
   endfunction

   // Works out the results of one byte transaction and queues them in order.
   function automatic void decode_byte(input logic [7:0] b, input logic l);
      logic [COUNT_W-1:0] held;
      logic [CODE_W-1:0]  val;
      point_type          p;
      step_points.delete();
      held = {1'b0, seq_held} + 3'd1;
      val = {seq_bits[14:0], b[5:0]};
      if (seq_len != LEN_NONE) begin
         if (b[7:6] == 2'b10) begin
            if (held >= seq_len) begin
               add_point(val, seq_len, 1'b0);
               clear_sequence();
            end else if (l) begin
               repeat (held) add_point(replacement_now, LEN_ONE, 1'b1);
               clear_sequence();
            end else begin
               seq_held = held[HELD_W-1:0];
               seq_bits = val;
            end
         end else begin
            repeat (seq_held) add_point(replacement_now, LEN_ONE, 1'b1);
            clear_sequence();
            take_lead(b, l);
         end
      end else begin
         take_lead(b, l);
      end
      if (l) clear_sequence();
      if (step_points.size() > 0) begin
         p = step_points.pop_back();
         p.run_last = 1'b1;
         p.text_end = l;
         step_points.push_back(p);
      end
      foreach (step_points[i]) expected_points.push_back(step_points[i]);
   endfunction

   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         replacement_now = REPLACEMENT_RESET;
         clear_sequence();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               flag_error("unexpected code_point", rsp_code_point, 0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_code_point !== want.code)
                  flag_error("code_point", rsp_code_point, want.code);
               if (rsp_byte_count !== want.count)
                  flag_error("byte_count", rsp_byte_count, want.count);
               if (rsp_malformed !== want.bad)
                  flag_error("malformed", rsp_malformed, want.bad);
               if (rsp_run_last !== want.run_last)
                  flag_error("run_last", rsp_run_last, want.run_last);
               if (rsp_text_end !== want.text_end)
                  flag_error("text_end", rsp_text_end, want.text_end);
            end
         end
         if (csr_valid && csr_ready) replacement_now = csr_replacement_code;
         if (req_valid && req_ready) decode_byte(req_text_byte, req_text_last);
      end
   end

   always @(negedge clock) begin
      if (steady || stall_left == 0) begin
         rsp_ready = 1'b1;
         if (!steady) stall_left = pick_pause();
      end else begin
         rsp_ready = 1'b0;
         stall_left--;
      end
   end

   // The byte stays valid after its transaction until the next call or settle_results changes it.
   task automatic send_byte(input logic [7:0] b, input logic l);
      int gap;
      gap = steady ? 0 : pick_pause();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_text_byte = b;
      req_text_last = l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle_results();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_points.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_points.size() != 0) begin
         flag_error("missing results", expected_points.size(), 0);
         expected_points.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_replacement(input logic [CODE_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_replacement_code = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_ascii();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h41, 1'b1);
   endtask

   task automatic test_multibyte();
      send_byte(8'hC2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF7, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
   endtask

   task automatic test_malformed();
      send_byte(8'hBF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
   endtask

   task automatic test_early_end();
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
      send_byte(8'hC3, 1'b1);
   endtask

   function automatic logic [7:0] lead_for(input int n);
      if (n == 2) return {3'b110, 5'($urandom_range(0, 31))};
      else if (n == 3) return {4'b1110, 4'($urandom_range(0, 15))};
      else return {5'b11110, 3'($urandom_range(0, 7))};
   endfunction

   task automatic send_text_chunk(inout int sent);
      logic [7:0] chunk[$];
      int         kind;
      int         n;
      logic       ends;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         chunk.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 70) begin
         n = $urandom_range(2, 4);
         chunk.push_back(lead_for(n));
         repeat (n - 1) chunk.push_back({2'b10, 6'($urandom_range(0, 63))});
      end else if (kind < 80) begin
         n = $urandom_range(2, 4);
         chunk.push_back(lead_for(n));
         repeat ($urandom_range(0, n - 2)) chunk.push_back({2'b10, 6'($urandom_range(0, 63))});
      end else if (kind < 88) begin
         chunk.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 93) begin
         chunk.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
         chunk.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      end
      ends = ($urandom_range(0, 9) == 0);
      foreach (chunk[i]) send_byte(chunk[i], ends && (i == chunk.size() - 1));
      sent += chunk.size();
   endtask

   task automatic test_random_text(input logic [CODE_W-1:0] code, input int items);
      int sent;
      sent = 0;
      settle_results();
      write_replacement(code);
      while (sent < items) begin
         if ($urandom_range(0, 19) == 0) steady = !steady;
         if ($urandom_range(0, 59) == 0) settle_results();
         send_text_chunk(sent);
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_text_byte = '0;
      req_text_last = 1'b0;
      csr_valid = 1'b0;
      csr_replacement_code = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_ascii();
      test_multibyte();
      test_malformed();
      test_early_end();
      test_random_text(21'h000000, 50);
      test_random_text(21'h1FFFFF, 50);
      test_random_text(CODE_W'($urandom_range(0, 21'h1FFFFF)), 50);
      test_random_text(REPLACEMENT_RESET, 50);
      settle_results();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
